FILE: design/shortest_path_relax_engine_macros.svh
// Assertion macros used by the shortest path relax engine controller.
`ifndef SHORTEST_PATH_RELAX_ENGINE_MACROS_SVH
`define SHORTEST_PATH_RELAX_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SRPE_CHECK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define SRPE_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   `SRPE_CHECK(lbl, clk, rst, (ante) |=> (cons))
`else
`define SRPE_CHECK(lbl, clk, rst, prop)
`define SRPE_CHECK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/srpe_pkg.sv
// Shared types and constants of the shortest path relax engine.
package srpe_pkg;
   localparam int MAX_NODES  = 256;
   localparam int IDX_BITS   = $clog2(MAX_NODES);
   localparam int COUNT_BITS = 9;
   localparam int COORD_BITS = 12;
   localparam int DIST_BITS  = 32;
   localparam int PRED_BITS  = 9;
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int ROOT_STEPS = COORD_BITS + 1;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_RELAX = 2'd1;
   localparam logic [1:0] REQ_FIND  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [1:0] ST_OPEN   = 2'd1;
   localparam logic [1:0] ST_CLOSED = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [DIST_BITS-1:0]  distance;
      logic [PRED_BITS-1:0]  pred;
      logic [1:0]            state;
   } entry_type;

   typedef enum logic [1:0] {RD_SRC, RD_NB, RD_SCAN} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_LOAD, WR_NB, WR_CLOSE} wr_op_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
      logic       cap_src;
      logic       cap_nb;
      logic       calc_sq;
      logic       root_start;
      logic       calc_cand;
      logic       do_update;
      logic       read_out;
      logic       fix_self;
      logic       scan_inc;
      logic       find_done;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic nb_valid;
      logic last_edge;
      logic root_done;
      logic scan_end;
      logic scan_hit;
   } status_type;
endpackage

FILE: design/srpe_isqrt.sv
// Iterative floored integer square root, two result bits per step pair.
module srpe_isqrt
   import srpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_BITS-1:0]   value,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);
   localparam int CNT_BITS = $clog2(ROOT_STEPS + 1);

   logic [SQ_BITS-1:0]  rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [SQ_BITS:0]    trial;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = value;
         res_in  = '0;
         bit_in  = SQ_BITS'(1) << (2 * COORD_BITS);
         cnt_in  = CNT_BITS'(ROOT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[SQ_BITS-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];
endmodule

FILE: design/srpe_dpath.sv
// Datapath: node table memory, distance arithmetic, scan counter, result registers.
module srpe_dpath
   import srpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data,
   input  logic [IDX_BITS-1:0]   req_node_index,
   input  logic [IDX_BITS-1:0]   req_neighbor_index,
   input  logic                  req_neighbor_valid,
   input  logic                  req_last_edge,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [DIST_BITS-1:0]  req_init_dist,
   input  logic [PRED_BITS-1:0]  req_init_pred,
   input  logic [1:0]            req_init_state,
   output logic [COUNT_BITS-1:0] rsp_open_index,
   output logic [DIST_BITS-1:0]  rsp_dist_value,
   output logic [PRED_BITS-1:0]  rsp_pred_value,
   output logic                  rsp_improved,
   output logic [1:0]            rsp_state_value
);
   entry_type mem [MAX_NODES];
   entry_type rd_data_ff, wr_data;
   entry_type load_ff;
   logic [IDX_BITS-1:0] src_ff, nb_ff, rd_addr, wr_addr;
   logic nb_valid_ff, last_ff, wr_en;
   logic [COUNT_BITS-1:0] count_ff, bound, scan_ff;
   logic [COORD_BITS-1:0] src_x_ff, src_y_ff, dx_ff, dy_ff;
   logic [DIST_BITS-1:0] src_dist_ff, cand_ff;
   entry_type nb_ff_e;
   logic [2*COORD_BITS-1:0] dx2_ff, dy2_ff;
   logic [SQ_BITS-1:0] sq_sum;
   logic root_done;
   logic [ROOT_BITS-1:0] root;
   logic [DIST_BITS:0] cand_sum;
   logic improved;
   logic [COUNT_BITS-1:0] res_open_ff;
   logic [DIST_BITS-1:0] res_dist_ff;
   logic [PRED_BITS-1:0] res_pred_ff;
   logic res_impr_ff;
   logic [1:0] res_state_ff;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign bound = (count_ff > COUNT_BITS'(MAX_NODES)) ? COUNT_BITS'(MAX_NODES) : count_ff;
   assign sq_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign cand_sum = {1'b0, src_dist_ff} + (DIST_BITS+1)'(root);
   assign improved = cand_ff < nb_ff_e.distance;

   always_comb begin
      case (cmd.rd_sel)
         RD_SRC:  rd_addr = src_ff;
         RD_NB:   rd_addr = nb_ff;
         RD_SCAN: rd_addr = scan_ff[IDX_BITS-1:0];
         default: rd_addr = src_ff;
      endcase
      wr_data = rd_data_ff;
      wr_addr = src_ff;
      wr_en   = 1'b0;
      case (cmd.wr_op)
         WR_LOAD: begin
            wr_data = load_ff;
            wr_en   = 1'b1;
         end
         WR_NB: begin
            wr_data          = nb_ff_e;
            wr_data.distance = cand_ff;
            wr_data.pred     = PRED_BITS'(src_ff);
            wr_data.state    = (nb_ff_e.state == ST_CLOSED) ? ST_CLOSED : ST_OPEN;
            wr_addr          = nb_ff;
            wr_en            = improved;
         end
         WR_CLOSE: begin
            wr_data.state = ST_CLOSED;
            wr_en         = 1'b1;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   srpe_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_start),
      .value (sq_sum),
      .done  (root_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
      if (cmd.latch_req) begin
         src_ff        <= req_node_index;
         nb_ff         <= req_neighbor_index;
         nb_valid_ff   <= req_neighbor_valid;
         last_ff       <= req_last_edge;
         load_ff       <= '{x: req_coord_x, y: req_coord_y, distance: req_init_dist,
                            pred: req_init_pred, state: req_init_state};
         scan_ff       <= '0;
         res_open_ff   <= '0;
         res_dist_ff   <= '0;
         res_pred_ff   <= '0;
         res_impr_ff   <= 1'b0;
         res_state_ff  <= '0;
      end
      if (cmd.cap_src) begin
         src_x_ff    <= rd_data_ff.x;
         src_y_ff    <= rd_data_ff.y;
         src_dist_ff <= rd_data_ff.distance;
      end
      if (cmd.cap_nb) begin
         nb_ff_e <= rd_data_ff;
         dx_ff   <= abs_diff(src_x_ff, rd_data_ff.x);
         dy_ff   <= abs_diff(src_y_ff, rd_data_ff.y);
      end
      if (cmd.calc_sq) begin
         dx2_ff <= dx_ff * dx_ff;
         dy2_ff <= dy_ff * dy_ff;
      end
      if (cmd.calc_cand) begin
         cand_ff <= cand_sum[DIST_BITS] ? '1 : cand_sum[DIST_BITS-1:0];
      end
      if (cmd.do_update) begin
         res_impr_ff  <= improved;
         res_dist_ff  <= improved ? cand_ff : nb_ff_e.distance;
         res_pred_ff  <= improved ? PRED_BITS'(src_ff) : nb_ff_e.pred;
         res_state_ff <= (improved && nb_ff_e.state != ST_CLOSED) ? ST_OPEN : nb_ff_e.state;
      end
      if (cmd.read_out) begin
         res_dist_ff  <= rd_data_ff.distance;
         res_pred_ff  <= rd_data_ff.pred;
         res_state_ff <= rd_data_ff.state;
      end
      // A closed self-edge reports the source's closed state.
      if (cmd.fix_self && nb_valid_ff && nb_ff == src_ff) begin
         res_state_ff <= ST_CLOSED;
      end
      if (cmd.scan_inc) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.find_done) begin
         res_open_ff <= scan_ff;
      end
      if (cmd.rsp_load) begin
         rsp_open_index  <= res_open_ff;
         rsp_dist_value  <= res_dist_ff;
         rsp_pred_value  <= res_pred_ff;
         rsp_improved    <= res_impr_ff;
         rsp_state_value <= res_state_ff;
      end
   end

   assign status.nb_valid  = nb_valid_ff;
   assign status.last_edge = last_ff;
   assign status.root_done = root_done;
   assign status.scan_end  = scan_ff == bound;
   assign status.scan_hit  = rd_data_ff.state == ST_OPEN;
endmodule

FILE: design/srpe_ctrl.sv
// Controller state machine: sequences each transaction over the datapath.
`include "shortest_path_relax_engine_macros.svh"
module srpe_ctrl
   import srpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_READ_RD, S_READ_OUT, S_REL_SRC, S_REL_NB, S_REL_DIFF,
      S_REL_SQ, S_REL_SUM, S_ROOT, S_ADD, S_UPD, S_CLS_RD, S_CLS_WR,
      S_FIND_CHK, S_FIND_TST, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign accept = req_valid && state_ff == S_IDLE;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_SRC;
      cmd.wr_op    = WR_NONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               case (req_type)
                  REQ_LOAD:  state_in = S_LOAD;
                  REQ_RELAX: state_in = S_REL_SRC;
                  REQ_FIND:  state_in = S_FIND_CHK;
                  REQ_READ:  state_in = S_READ_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.wr_op = WR_LOAD;
            state_in  = S_RESP;
         end
         S_READ_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_READ_OUT;
         end
         S_READ_OUT: begin
            cmd.read_out = 1'b1;
            state_in     = S_RESP;
         end
         S_REL_SRC: begin
            cmd.rd_en = 1'b1;
            state_in  = status.nb_valid ? S_REL_NB : S_CLS_WR;
         end
         S_REL_NB: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_NB;
            cmd.cap_src = 1'b1;
            state_in    = S_REL_DIFF;
         end
         S_REL_DIFF: begin
            cmd.cap_nb = 1'b1;
            state_in   = S_REL_SQ;
         end
         S_REL_SQ: begin
            cmd.calc_sq = 1'b1;
            state_in    = S_REL_SUM;
         end
         S_REL_SUM: begin
            cmd.root_start = 1'b1;
            state_in       = S_ROOT;
         end
         S_ROOT: begin
            if (status.root_done) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.calc_cand = 1'b1;
            state_in      = S_UPD;
         end
         S_UPD: begin
            cmd.do_update = 1'b1;
            cmd.wr_op     = WR_NB;
            state_in      = status.last_edge ? S_CLS_RD : S_RESP;
         end
         S_CLS_RD: begin
            // Reread the source: a self-edge may have just rewritten it.
            cmd.rd_en = 1'b1;
            state_in  = S_CLS_WR;
         end
         S_CLS_WR: begin
            cmd.wr_op    = WR_CLOSE;
            cmd.fix_self = 1'b1;
            state_in     = S_RESP;
         end
         S_FIND_CHK: begin
            if (status.scan_end) begin
               cmd.find_done = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SCAN;
               state_in   = S_FIND_TST;
            end
         end
         S_FIND_TST: begin
            if (status.scan_hit) begin
               cmd.find_done = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_FIND_CHK;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `SRPE_CHECK_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `SRPE_CHECK(a_no_overwrite, clock, reset, cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
   `SRPE_CHECK_NEXT(a_root_to_add, clock, reset, state_ff == S_ROOT && status.root_done, state_ff == S_ADD)
endmodule

FILE: design/shortest_path_relax_engine.sv
// Top level of the shortest path relax engine: controller, datapath and ports.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_type .. req_init_state
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_open_index .. rsp_state_value
//   csr     | in        | csr_wr_en (no wait)    | csr_wr_data (node count)
//
// One transaction at a time, plus one result waiting in the output register.
// Relax waits on the 13-step square root unit; a relax that closes the source
// adds a reread and a write of the source, and one with no neighbor only closes it.
// Find walks the node table one entry at a time, from index 0 up to the scan bound
// (the node count, at most 256), and stops at the first open node.
// Reset is synchronous and clears control and the node count, not the table.
// A stalled result holds the engine in its last step until rsp_ready rises.
module shortest_path_relax_engine
   import srpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [IDX_BITS-1:0]   req_node_index,
   input  logic [IDX_BITS-1:0]   req_neighbor_index,
   input  logic                  req_neighbor_valid,
   input  logic                  req_last_edge,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [DIST_BITS-1:0]  req_init_dist,
   input  logic signed [PRED_BITS-1:0] req_init_pred,
   input  logic [1:0]            req_init_state,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] rsp_open_index,
   output logic [DIST_BITS-1:0]  rsp_dist_value,
   output logic signed [PRED_BITS-1:0] rsp_pred_value,
   output logic                  rsp_improved,
   output logic [1:0]            rsp_state_value
);
   cmd_type    cmd;
   status_type status;

   // Sequence each transaction: issue reads, writes and arithmetic steps.
   srpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the node table, the relax arithmetic and the result registers.
   srpe_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_node_index     (req_node_index),
      .req_neighbor_index (req_neighbor_index),
      .req_neighbor_valid (req_neighbor_valid),
      .req_last_edge      (req_last_edge),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_init_dist      (req_init_dist),
      .req_init_pred      (req_init_pred),
      .req_init_state     (req_init_state),
      .rsp_open_index     (rsp_open_index),
      .rsp_dist_value     (rsp_dist_value),
      .rsp_pred_value     (rsp_pred_value),
      .rsp_improved       (rsp_improved),
      .rsp_state_value    (rsp_state_value)
   );
endmodule
